// File: src/assert_macros.svh
// Assertion macros shared by the search unit RTL.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ats_pkg.sv
// Package for the approximate timestamp search unit: sizes, codes and transfer structs.
// It has no dependencies. The engine and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

	// Table geometry and field widths.
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int TS_W        = 48;
	localparam int ACT_W       = 2;
	localparam int STAT_W      = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_EXACT  = 3'd0,
		ST_APPROX = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_FULL   = 3'd3,
		ST_DONE   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_SEARCH,
		ENG_RESULT
	} eng_state_t;

	// One request as taken from the input stream.
	typedef struct packed {
		action_t         action;
		logic [TS_W-1:0] timestamp;
	} req_t;

	// One result as handed to the output stream.
	typedef struct packed {
		logic [TS_W-1:0] match_time;
		status_t         status;
	} res_t;

	// Midpoint (low + high) >> 1, where the upper bound is held as high + 1.
	// The caller guarantees low < high + 1, so the sum never goes negative.
	function automatic logic [ADDR_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
			input logic [CNT_W-1:0] hi1);
		logic [CNT_W:0] sum;
		sum = {1'b0, lo} + {1'b0, hi1} - (CNT_W+1)'(1);
		return sum[ADDR_W:1];
	endfunction

endpackage

`default_nettype wire

// File: src/approximate_timestamp_search_unit.sv
// Approximate timestamp search unit: streaming wrapper with the output register.
// Depends on ats_pkg, ats_engine and assert_macros.svh.
// Append, clear and unused codes pass the engine's result state, then the output register;
// a query searches first, P probes being at most floor(log2(entry count)) + 1 (11 here).
// One table read a probe; no new item is taken while a result is still in the engine.
// Reset clears the count but not the table; entries at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module approximate_timestamp_search_unit
	import ats_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [TS_W-1:0]   s_tdata,   // [47:0] timestamp
	input  wire logic [ACT_W-1:0]  s_tuser,   // [1:0] action
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [TS_W-1:0]   m_tdata,   // [47:0] match_time
	output logic      [STAT_W-1:0] m_tuser    // [2:0] status
);

	req_t req;
	res_t res;
	logic res_valid;
	logic res_ready;
	logic m_tvalid_q;
	res_t out_q;

	assign req.action    = action_t'(s_tuser);
	assign req.timestamp = s_tdata;

	ats_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// The output register takes a new result when it is empty or being drained.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q.match_time;
	assign m_tuser  = out_q.status;

	`ASSERT_NEXT(a_handoff_lands, res_valid && res_ready, m_tvalid_q, "result lost at hand-off")
	`ASSERT_NEXT(a_valid_held, m_tvalid_q && !m_tready, m_tvalid_q, "valid dropped while stalled")
	`ASSERT_NEXT(a_data_held, m_tvalid_q && !m_tready, $stable(out_q), "data changed while stalled")

endmodule

`default_nettype wire

// File: src/ats_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module ats_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: src/ats_engine.sv
// Search engine: entry count, the timestamp table memory and the binary search sequencer.
// Depends on ats_pkg, ats_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ats_engine
	import ats_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);

	eng_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  lo_q, lo_d;
	logic [CNT_W-1:0]  hi1_q, hi1_d;
	logic [ADDR_W-1:0] mid_q, mid_d;
	logic [TS_W-1:0]   key_q, key_d;
	res_t              res_q, res_d;

	logic              wr_en;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [TS_W-1:0]   rd_data;

	logic              probe_gt;
	logic              probe_lt;
	logic [CNT_W-1:0]  lo_nx;
	logic [CNT_W-1:0]  hi1_nx;
	logic [ADDR_W-1:0] mid_nx;
	logic [ADDR_W-1:0] mid_init;
	logic              full;

	logic              query_go;
	logic              bounds_ok;

	// The table. Appends write at the current count and a query only reads below it,
	// and both happen in separate items, so no read ever meets a write to the same entry.
	ats_ram #(
		.WIDTH(TS_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(req.timestamp),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Compare the probed entry and narrow the bounds for the next probe.
	always_comb begin
		probe_gt = rd_data > key_q;
		probe_lt = rd_data < key_q;
		lo_nx    = probe_lt ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
		hi1_nx   = probe_gt ? CNT_W'(mid_q) : hi1_q;
		mid_nx   = mid_of(lo_nx, hi1_nx);
		mid_init = mid_of('0, count_q);
		full     = count_q == CNT_W'(TABLE_DEPTH);
	end

	// Sequencer: next state, memory controls and result.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		lo_d      = lo_q;
		hi1_d     = hi1_q;
		mid_d     = mid_q;
		key_d     = key_q;
		res_d     = res_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = mid_q;
		req_ready = state_q == ENG_IDLE;
		res_valid = state_q == ENG_RESULT;
		case (state_q)
			ENG_IDLE: begin
				if (req_valid) begin
					key_d            = req.timestamp;
					res_d.match_time = '0;
					res_d.status     = ST_DONE;
					state_d          = ENG_RESULT;
					case (req.action)
						ACT_APPEND: begin
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end
						ACT_QUERY: begin
							if (count_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								lo_d    = '0;
								hi1_d   = count_q;
								mid_d   = mid_init;
								rd_en   = 1'b1;
								rd_addr = mid_init;
								state_d = ENG_SEARCH;
							end
						end
						ACT_CLEAR: begin
							count_d = '0;
						end
						default: begin
							// Unused code: no change, plain completion.
						end
					endcase
				end
			end
			ENG_SEARCH: begin
				if (!probe_gt && !probe_lt) begin
					res_d.match_time = rd_data;
					res_d.status     = ST_EXACT;
					state_d          = ENG_RESULT;
				end else if (lo_nx >= hi1_nx) begin
					res_d.match_time = rd_data;
					res_d.status     = ST_APPROX;
					state_d          = ENG_RESULT;
				end else begin
					lo_d    = lo_nx;
					hi1_d   = hi1_nx;
					mid_d   = mid_nx;
					rd_en   = 1'b1;
					rd_addr = mid_nx;
				end
			end
			ENG_RESULT: begin
				if (res_ready) begin
					state_d = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Search bounds, key and result payload.
	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi1_q <= hi1_d;
		mid_q <= mid_d;
		key_q <= key_d;
		res_q <= res_d;
	end

	assign res = res_q;

	// Conditions checked by the assertions below.
	assign query_go  = (state_q == ENG_IDLE) && req_valid && (req.action == ACT_QUERY)
		&& (count_q != '0);
	assign bounds_ok = (lo_q < hi1_q) && (hi1_q <= count_q) && (CNT_W'(mid_q) < hi1_q)
		&& (CNT_W'(mid_q) >= lo_q);

	`ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
	`ASSERT_ALWAYS(a_search_bounds, (state_q != ENG_SEARCH) || bounds_ok, "probe outside bounds")
	`ASSERT_NEXT(a_query_starts, query_go, state_q == ENG_SEARCH, "query did not start a search")

endmodule

`default_nettype wire

// File: tb/tb_approximate_timestamp_search_unit.sv
// Self-checking testbench for the approximate timestamp search unit.
// It depends on ats_pkg and the unit itself; a built-in predictor mirrors the table and the
// binary search, and every result transfer is checked against it in order.
`timescale 1ns / 1ps

module tb_approximate_timestamp_search_unit;
	import ats_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
	localparam logic [TS_W-1:0]  TS_MAX      = {TS_W{1'b1}};
	localparam int               ITEM_TARGET = 1650;
	localparam int               QUIET_LIMIT = 2000;
	localparam int               DRAIN_CYCLES = 32;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [TS_W-1:0]   s_tdata  = '0;
	logic [ACT_W-1:0]  s_tuser  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [TS_W-1:0]   m_tdata;
	logic [STAT_W-1:0] m_tuser;

	// Shadow copy of the table and its fill level.
	logic [TS_W-1:0] shadow_table [TABLE_DEPTH];
	int              shadow_count = 0;

	res_t pending_results [$];
	int   error_count = 0;
	int   items_sent  = 0;
	int   quiet_cycles = 0;
	bit   idle_en = 1'b1;

	approximate_timestamp_search_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Applies one request to the shadow table and returns the result the unit should give.
	function automatic res_t predict_search_result(logic [ACT_W-1:0] act, logic [TS_W-1:0] ts);
		res_t r;
		int   lo;
		int   hi;
		int   mid;
		bit   hit;
		r.match_time = '0;
		r.status     = ST_DONE;
		case (act)
			ACT_APPEND: begin
				if (shadow_count < TABLE_DEPTH) begin
					shadow_table[shadow_count] = ts;
					shadow_count++;
				end else begin
					r.status = ST_FULL;
				end
			end
			ACT_QUERY: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					lo  = 0;
					hi  = shadow_count - 1;
					mid = 0;
					hit = 1'b0;
					while (lo <= hi && !hit) begin
						mid = (lo + hi) >> 1;
						if (shadow_table[mid] > ts) begin
							hi = mid - 1;
						end else if (shadow_table[mid] < ts) begin
							lo = mid + 1;
						end else begin
							hit = 1'b1;
						end
					end
					r.match_time = shadow_table[mid];
					r.status     = hit ? ST_EXACT : ST_APPROX;
				end
			end
			ACT_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [TS_W-1:0] rand_ts();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TS_W-1:0];
	endfunction

	// Picks a search key near the stored entries, or anywhere at all.
	function automatic logic [TS_W-1:0] pick_query_key();
		logic [TS_W-1:0] base;
		if (shadow_count == 0) begin
			return rand_ts();
		end
		base = shadow_table[$urandom_range(shadow_count - 1)];
		case ($urandom_range(5))
			0, 1:    return base;
			2:       return base + 1'b1;
			3:       return base - 1'b1;
			4:       return ($urandom_range(1) != 0) ? '0 : TS_MAX;
			default: return rand_ts();
		endcase
	endfunction

	// Offers one request on the input stream and waits for its transfer.
	task automatic send_item(logic [ACT_W-1:0] act, logic [TS_W-1:0] ts);
		if (idle_en) begin
			while ($urandom_range(99) < 8) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ts;
		s_tuser  <= act;
		pending_results.insert(pending_results.size(), predict_search_result(act, ts));
		items_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic test_empty_table();
		send_item(ACT_QUERY, '0);
		send_item(ACT_QUERY, TS_MAX);
		send_item(ACT_CLEAR, TS_MAX);
		send_item(ACT_UNUSED, TS_MAX);
		send_item(ACT_UNUSED, '0);
	endtask

	// A handful of entries, the extremes of the timestamp and an unordered table.
	task automatic test_small_tables();
		send_item(ACT_APPEND, 48'd0);
		send_item(ACT_APPEND, 48'd100);
		send_item(ACT_APPEND, 48'd200);
		send_item(ACT_APPEND, 48'd300);
		send_item(ACT_APPEND, TS_MAX);
		send_item(ACT_QUERY, 48'd200);
		send_item(ACT_QUERY, 48'd0);
		send_item(ACT_QUERY, TS_MAX);
		send_item(ACT_QUERY, 48'd150);
		send_item(ACT_QUERY, 48'd1);
		send_item(ACT_QUERY, TS_MAX - 1'b1);
		send_item(ACT_UNUSED, 48'd200);
		send_item(ACT_CLEAR, '0);
		send_item(ACT_APPEND, 48'd500);
		send_item(ACT_APPEND, 48'd100);
		send_item(ACT_APPEND, 48'd900);
		send_item(ACT_QUERY, 48'd100);
		send_item(ACT_QUERY, 48'd500);
		send_item(ACT_CLEAR, '0);
		send_item(ACT_QUERY, 48'd500);
	endtask

	// Fills the table to the brim with no idling, then overflows it and searches it.
	task automatic test_full_table();
		logic [9:0]      idx;
		logic [TS_W-1:0] noise;
		idle_en = 1'b0;
		send_item(ACT_CLEAR, '0);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			idx   = i[9:0];
			noise = rand_ts();
			send_item(ACT_APPEND, {idx, noise[TS_W-11:0]});
		end
		idle_en = 1'b1;
		send_item(ACT_APPEND, '0);
		send_item(ACT_APPEND, TS_MAX);
		send_item(ACT_QUERY, shadow_table[0]);
		send_item(ACT_QUERY, shadow_table[TABLE_DEPTH - 1]);
		send_item(ACT_QUERY, shadow_table[TABLE_DEPTH / 2]);
		send_item(ACT_QUERY, '0);
		send_item(ACT_QUERY, TS_MAX);
		for (int i = 0; i < 20; i++) begin
			send_item(ACT_QUERY, pick_query_key());
		end
		send_item(ACT_CLEAR, '0);
	endtask

	// Mostly sorted tables built after a clear and then searched, with noise and
	// unordered tables mixed in.
	task automatic test_random_traffic();
		int              kind;
		int              n;
		logic [TS_W-1:0] cur;
		logic [TS_W:0]   nxt;
		logic [TS_W-1:0] gap;
		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(99);
			if (kind < 75) begin
				send_item(ACT_CLEAR, rand_ts());
				n   = ($urandom_range(9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 24);
				cur = rand_ts() >> $urandom_range(1, TS_W - 1);
				for (int i = 0; i < n; i++) begin
					send_item(ACT_APPEND, cur);
					gap = ($urandom_range(1) != 0) ? TS_W'($urandom_range(8))
						: rand_ts() >> $urandom_range(8, TS_W - 1);
					nxt = {1'b0, cur} + {1'b0, gap};
					cur = nxt[TS_W] ? TS_MAX : nxt[TS_W-1:0];
				end
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					send_item(ACT_QUERY, pick_query_key());
				end
			end else if (kind < 90) begin
				send_item(ACT_W'($urandom_range(3)), rand_ts());
			end else begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					send_item(ACT_APPEND, rand_ts());
				end
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					send_item(ACT_QUERY, pick_query_key());
				end
			end
		end
	endtask

	// Result checker and receiver back-pressure.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: match_time %0d status %0d", m_tdata, m_tuser);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.match_time) begin
					$error("match_time: expected %0d, actual %0d", want.match_time, m_tdata);
					error_count++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser);
					error_count++;
				end
			end
		end
		m_tready <= !idle_en || ($urandom_range(99) >= 8);
	end

	// Watchdog on cycles in which neither stream moves a transfer.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("approximate_timestamp_search_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_small_tables();
		test_full_table();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("approximate_timestamp_search_unit verification clean");
		end else begin
			$display("approximate_timestamp_search_unit verification failed");
		end
		$finish;
	end

endmodule
